// ===== sv/assert_macros.svh =====
// Assertion macros shared by the verification checkers.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must be followed by a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("assertion failed");

`endif

// ===== sv/tcr_pkg.sv =====
// Package for the token class recognizer: state and class encodings,
// configuration types and character class helpers. No dependencies.
package tcr_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned CountW = 6;
  localparam int unsigned CfgW   = 6;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [CfgW-1:0] MinFloatLenRst  = CfgW'(3);
  localparam logic [CfgW-1:0] MaxNumberLenRst = CfgW'(50);
  localparam logic [CfgW-1:0] MaxIdentLenRst  = CfgW'(10);

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_FLOAT_LEN  = 2'd0,
    REG_MAX_NUMBER_LEN = 2'd1,
    REG_MAX_IDENT_LEN  = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_START    = 4'd0,
    ST_MINUS    = 4'd1,
    ST_ZERO_POS = 4'd2,
    ST_ZERO_NEG = 4'd3,
    ST_INT_HEAD = 4'd4,
    ST_POINT    = 4'd5,
    ST_FRAC     = 4'd6,
    ST_INT_BODY = 4'd8,
    ST_ID_FIRST = 4'd10,
    ST_ID_REST  = 4'd11,
    ST_STRING   = 4'd13
  } scan_state_e;

  typedef enum logic [1:0] {
    CLS_FLOAT    = 2'd0,
    CLS_INTEGER  = 2'd1,
    CLS_VARIABLE = 2'd2,
    CLS_STRING   = 2'd3
  } token_class_e;

  typedef struct packed {
    logic [CfgW-1:0] min_float_len;
    logic [CfgW-1:0] max_number_len;
    logic [CfgW-1:0] max_ident_len;
  } cfg_t;

  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChPoint = 8'h2E;
  localparam logic [CharW-1:0] ChUnder = 8'h5F;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  function automatic logic is_digit(logic [CharW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_alpha(logic [CharW-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == ChUnder);
  endfunction

endpackage

// ===== sv/token_class_recognizer.sv =====
// Token class recognizer, top level: configuration registers, recognizer and
// the registered result stage with a skid entry. Uses tcr_pkg and tcr_scan.
//
// Usage: characters of a token arrive one per request on the input channel
// (in_valid_i / in_stall_o, char_byte_i). A zero byte ends the token and
// produces exactly one result on the output channel (out_valid_o /
// out_stall_i, token_class_o): 0 float, 1 integer, 2 variable, 3 string.
// Other bytes produce no result.
// Throughput is one character per cycle while in_stall_o is low. A result
// reaches the output through the result register, via the skid entry when that register is held.
// A skid entry behind the result register lets the block keep taking
// characters while a result waits; the input stalls only when both hold a
// result, and only then.
// The three length limits are written through cfg_we_i / cfg_idx_i / cfg_wdata_i;
// the user must do so only while the block is idle, the block does not enforce it; index 3 is ignored.
// Reset returns the recognizer to its start state, clears the count, empties
// the output stage and loads the limits with 3, 50 and 10.
module token_class_recognizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tcr_pkg::CharW-1:0]     char_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    token_class_o,
  input  logic                          cfg_we_i,
  input  logic [tcr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tcr_pkg::CfgW-1:0]      cfg_wdata_i
);
  import tcr_pkg::*;

  cfg_t          cfg_q;
  logic          in_accept;
  logic          res_valid;
  token_class_e  end_class;
  logic          out_free;

  logic          out_valid_q, skid_valid_q;
  token_class_e  out_class_q, skid_class_q;

  assign in_accept = in_valid_i && !in_stall_o;
  assign res_valid = in_accept && (char_byte_i == '0);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_float_len  <= MinFloatLenRst;
      cfg_q.max_number_len <= MaxNumberLenRst;
      cfg_q.max_ident_len  <= MaxIdentLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_FLOAT_LEN:  cfg_q.min_float_len  <= cfg_wdata_i;
        REG_MAX_NUMBER_LEN: cfg_q.max_number_len <= cfg_wdata_i;
        REG_MAX_IDENT_LEN:  cfg_q.max_ident_len  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tcr_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_accept),
    .char_byte_i (char_byte_i),
    .cfg_i       (cfg_q),
    .end_class_o (end_class)
  );

  // The skid entry fills only while the result register is held, so the
  // input never sees a new request while the skid entry is occupied.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_class_q <= skid_valid_q ? skid_class_q : end_class;
    end
    if (!out_free && res_valid) begin
      skid_class_q <= end_class;
    end
  end

  assign in_stall_o    = skid_valid_q;
  assign out_valid_o   = out_valid_q;
  assign token_class_o = out_class_q;

endmodule

// ===== sv/tcr_scan.sv =====
// Recognizer state machine and character counter of the token class recognizer.
// Uses tcr_pkg for encodings, configuration type and character classes.
module tcr_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [tcr_pkg::CharW-1:0]  char_byte_i,
  input  tcr_pkg::cfg_t              cfg_i,
  output tcr_pkg::token_class_e      end_class_o
);
  import tcr_pkg::*;

  scan_state_e        state_q, state_d;
  logic [CountW-1:0]  count_q, count_d;
  scan_state_e        step_state;

  // Transition for one non-terminating character.
  always_comb begin
    step_state = ST_STRING;
    unique case (state_q)
      ST_START: begin
        if (char_byte_i == ChMinus)       step_state = ST_MINUS;
        else if (char_byte_i == ChZero)   step_state = ST_ZERO_POS;
        else if (is_digit(char_byte_i))   step_state = ST_INT_HEAD;
        else if (is_alpha(char_byte_i))   step_state = ST_ID_FIRST;
      end
      ST_MINUS: begin
        if (char_byte_i == ChZero)        step_state = ST_ZERO_NEG;
        else if (is_digit(char_byte_i))   step_state = ST_INT_HEAD;
      end
      ST_ZERO_POS, ST_ZERO_NEG: begin
        if (char_byte_i == ChPoint)       step_state = ST_POINT;
      end
      ST_INT_HEAD, ST_INT_BODY: begin
        if (char_byte_i == ChPoint)       step_state = ST_POINT;
        else if (is_digit(char_byte_i))   step_state = ST_INT_BODY;
      end
      ST_POINT, ST_FRAC: begin
        if (is_digit(char_byte_i))        step_state = ST_FRAC;
      end
      ST_ID_FIRST, ST_ID_REST: begin
        if (is_alpha(char_byte_i) || is_digit(char_byte_i)) step_state = ST_ID_REST;
      end
      default: step_state = ST_STRING;
    endcase
  end

  // A zero byte closes the token and rearms the recognizer.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    if (step_i) begin
      if (char_byte_i == '0) begin
        state_d = ST_START;
        count_d = '0;
      end else begin
        state_d = step_state;
        if (count_q != CountMax) count_d = count_q + CountW'(1);
      end
    end
  end

  always_comb begin
    end_class_o = CLS_STRING;
    unique case (state_q)
      ST_FRAC: begin
        if ((count_q >= cfg_i.min_float_len) && (count_q <= cfg_i.max_number_len))
          end_class_o = CLS_FLOAT;
      end
      ST_ZERO_POS, ST_INT_HEAD, ST_INT_BODY: begin
        if ((count_q != '0) && (count_q <= cfg_i.max_number_len))
          end_class_o = CLS_INTEGER;
      end
      ST_ID_FIRST, ST_ID_REST: begin
        if ((count_q != '0) && (count_q <= cfg_i.max_ident_len))
          end_class_o = CLS_VARIABLE;
      end
      default: end_class_o = CLS_STRING;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== sv/tcr_checker.sv =====
// Port-level checker for the token class recognizer, bound to the top level.
// Uses assert_macros.svh and tcr_pkg.
`include "assert_macros.svh"

module tcr_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [tcr_pkg::CharW-1:0]     char_byte_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [1:0]                    token_class_o
);
  import tcr_pkg::*;

  logic in_acc;
  logic out_held;
  logic tok_end;
  logic tok_char;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign tok_end  = in_acc && (char_byte_i == '0);
  assign tok_char = in_acc && (char_byte_i != '0);

  // A stalled result keeps its valid and its class.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(token_class_o))

  // The input stalls only when a result is already waiting at the output.
  `ASSERT_PROP(a_stall_needs_result, clk_i, rst_ni, !in_stall_o || out_valid_o)

  // A token end taken into an empty output gives a valid result next cycle.
  `ASSERT_NEXT(a_end_gives_result, clk_i, rst_ni, tok_end && !out_valid_o, out_valid_o)

  // A character inside a token taken into an empty output gives no result.
  `ASSERT_NEXT(a_char_no_result, clk_i, rst_ni, tok_char && !out_valid_o, !out_valid_o)

endmodule

bind token_class_recognizer tcr_checker u_tcr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .char_byte_i   (char_byte_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .token_class_o (token_class_o)
);

// ===== tb/token_class_recognizer_test.sv =====
// Self-checking testbench for token_class_recognizer: it streams token characters,
// predicts each token class in a behavioral model and checks every result.
// Depends on tcr_pkg and the token_class_recognizer RTL only.
module token_class_recognizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcr_pkg::*;

  localparam logic [CharW-1:0]   ChEnd     = 8'h00;
  localparam logic [CfgIdxW-1:0] RegSpare  = 2'd3;
  localparam int                 RunLimit  = 4_000_000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [CharW-1:0]    char_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          token_class_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;

  // Behavioral copy of the recognizer and its limits.
  cfg_t                limits;
  scan_state_e         scan_st;
  logic [CountW-1:0]   tok_len;
  token_class_e        expected_classes[$];
  token_class_e        oldest_class;
  logic [CharW-1:0]    token_chars[$];

  int gap_pct;
  int stall_pct;
  int fail_count;
  int chars_sent;
  int tokens_sent;
  int results_checked;
  int cfg_writes;

  token_class_recognizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_byte_i   (char_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_class_o (token_class_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic bit char_is_numeral(logic [CharW-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit char_is_letter(logic [CharW-1:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == ChUnder);
  endfunction

  function automatic scan_state_e advance_scan(scan_state_e s, logic [CharW-1:0] c);
    case (s)
      ST_START: begin
        if (c == ChMinus) return ST_MINUS;
        if (c == ChZero) return ST_ZERO_POS;
        if (char_is_numeral(c)) return ST_INT_HEAD;
        if (char_is_letter(c)) return ST_ID_FIRST;
        return ST_STRING;
      end
      ST_MINUS: begin
        if (c == ChZero) return ST_ZERO_NEG;
        if (char_is_numeral(c)) return ST_INT_HEAD;
        return ST_STRING;
      end
      ST_ZERO_POS, ST_ZERO_NEG: begin
        if (c == ChPoint) return ST_POINT;
        return ST_STRING;
      end
      ST_INT_HEAD, ST_INT_BODY: begin
        if (c == ChPoint) return ST_POINT;
        if (char_is_numeral(c)) return ST_INT_BODY;
        return ST_STRING;
      end
      ST_POINT, ST_FRAC: begin
        if (char_is_numeral(c)) return ST_FRAC;
        return ST_STRING;
      end
      ST_ID_FIRST, ST_ID_REST: begin
        if (char_is_letter(c) || char_is_numeral(c)) return ST_ID_REST;
        return ST_STRING;
      end
      default: return ST_STRING;
    endcase
  endfunction

  function automatic token_class_e class_at_token_end(scan_state_e s, logic [CountW-1:0] n);
    case (s)
      ST_FRAC:
        return (n >= limits.min_float_len && n <= limits.max_number_len) ?
               CLS_FLOAT : CLS_STRING;
      ST_ZERO_POS, ST_INT_HEAD, ST_INT_BODY:
        return (n >= 1 && n <= limits.max_number_len) ? CLS_INTEGER : CLS_STRING;
      ST_ID_FIRST, ST_ID_REST:
        return (n >= 1 && n <= limits.max_ident_len) ? CLS_VARIABLE : CLS_STRING;
      default: return CLS_STRING;
    endcase
  endfunction

  function automatic void track_char(logic [CharW-1:0] c);
    if (c == ChEnd) begin
      expected_classes.push_back(class_at_token_end(scan_st, tok_len));
      scan_st = ST_START;
      tok_len = '0;
    end else begin
      scan_st = advance_scan(scan_st, c);
      if (tok_len != CountMax) tok_len++;
    end
  endfunction

  // Results are taken at the same edge as the block sees them accepted.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_classes.size() == 0) begin
        $error("token_class: no request waiting, got %0d", token_class_o);
        fail_count++;
      end else begin
        oldest_class = expected_classes.pop_front();
        if (token_class_o !== oldest_class) begin
          $error("token_class: expected %0d, actual %0d", oldest_class, token_class_o);
          fail_count++;
        end
        results_checked++;
      end
    end
  end

  task automatic send_char(input logic [CharW-1:0] c);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_char(c);
    chars_sent++;
  endtask

  task automatic send_token();
    foreach (token_chars[i]) send_char(token_chars[i]);
    send_char(ChEnd);
    token_chars.delete();
    tokens_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) token_chars.push_back(s[i]);
    send_token();
  endtask

  // Stop sending and let every outstanding result come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_classes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_MIN_FLOAT_LEN:  limits.min_float_len  = value;
      REG_MAX_NUMBER_LEN: limits.max_number_len = value;
      REG_MAX_IDENT_LEN:  limits.max_ident_len  = value;
      default: ;
    endcase
    cfg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_limits(input int min_float, input int max_number, input int max_ident);
    drain();
    write_limit(REG_MIN_FLOAT_LEN, CfgW'(min_float));
    write_limit(REG_MAX_NUMBER_LEN, CfgW'(max_number));
    write_limit(REG_MAX_IDENT_LEN, CfgW'(max_ident));
    // The spare index must not disturb any limit.
    write_limit(RegSpare, CfgW'($urandom_range(0, 63)));
  endtask

  function automatic int rand_limit();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return 0;
        1: return 1;
        2: return 62;
        default: return 63;
      endcase
    end
    return $urandom_range(1, 12);
  endfunction

  function automatic logic [CharW-1:0] digit_char();
    return ChZero + CharW'($urandom_range(0, 9));
  endfunction

  function automatic logic [CharW-1:0] word_start_char();
    case ($urandom_range(0, 2))
      0: return "A" + CharW'($urandom_range(0, 25));
      1: return "a" + CharW'($urandom_range(0, 25));
      default: return ChUnder;
    endcase
  endfunction

  function automatic logic [CharW-1:0] word_char();
    return ($urandom_range(0, 3) == 0) ? digit_char() : word_start_char();
  endfunction

  task automatic add_integer(input int body);
    if ($urandom_range(0, 1)) token_chars.push_back(ChMinus);
    token_chars.push_back("1" + CharW'($urandom_range(0, 8)));
    repeat (body) token_chars.push_back(digit_char());
  endtask

  task automatic add_fraction(input int body);
    if ($urandom_range(0, 1)) begin
      if ($urandom_range(0, 1)) token_chars.push_back(ChMinus);
      token_chars.push_back(ChZero);
    end else begin
      add_integer($urandom_range(0, 3));
    end
    token_chars.push_back(ChPoint);
    repeat (body + 1) token_chars.push_back(digit_char());
  endtask

  task automatic add_identifier(input int body);
    token_chars.push_back(word_start_char());
    repeat (body) token_chars.push_back(word_char());
  endtask

  task automatic add_broken(input int body);
    case ($urandom_range(0, 4))
      0: token_chars.push_back(ChMinus);
      1: begin
        token_chars.push_back(ChMinus);
        token_chars.push_back(ChZero);
      end
      2: begin
        add_integer(body);
        token_chars.push_back(ChPoint);
      end
      3: begin
        token_chars.push_back(ChZero);
        repeat (body + 1) token_chars.push_back(digit_char());
      end
      default: begin
        case ($urandom_range(0, 2))
          0: add_integer(body);
          1: add_fraction(body);
          default: add_identifier(body);
        endcase
        token_chars[$urandom_range(0, token_chars.size() - 1)] =
          CharW'($urandom_range(1, 255));
      end
    endcase
  endtask

  task automatic send_random_token(input int long_pct);
    int pick;
    int body;
    pick = $urandom_range(0, 99);
    body = ($urandom_range(0, 99) < long_pct) ? $urandom_range(55, 70) : $urandom_range(0, 8);
    if (pick < 20) add_integer(body);
    else if (pick < 38) add_fraction(body);
    else if (pick < 58) add_identifier(body);
    else if (pick < 66) token_chars.push_back(ChZero);
    else if (pick < 82) add_broken(body);
    else if (pick < 95) repeat (body + 1) token_chars.push_back(CharW'($urandom_range(1, 255)));
    send_token();
  endtask

  // Short tokens of every class and early endings under the limits loaded by reset.
  task automatic test_reset_limits();
    gap_pct   = 0;
    stall_pct = 0;
    send_text("");
    send_text("-");
    send_text("-0");
    send_text("0");
    send_text("-5");
    send_text("0.5");
    send_text("-0.1");
    send_text("7.");
    send_text("a");
    send_text("_9");
    token_chars.push_back(8'hFF);
    token_chars.push_back(8'h80);
    send_token();
  endtask

  task automatic test_limit_extremes();
    int unsigned limit_sets [5][3];
    limit_sets = '{'{1, 62, 62}, '{62, 1, 1}, '{0, 0, 0}, '{63, 63, 63}, '{3, 2, 1}};
    gap_pct   = 20;
    stall_pct = 20;
    foreach (limit_sets[i]) begin
      set_limits(limit_sets[i][0], limit_sets[i][1], limit_sets[i][2]);
      repeat (5) send_random_token(0);
      // Long enough for the character count to saturate.
      add_identifier(63);
      send_token();
    end
  endtask

  task automatic test_random_tokens(input int gap, input int stall, input int n_chars);
    int target;
    bit reprogrammed;
    gap_pct      = gap;
    stall_pct    = stall;
    reprogrammed = 1'b0;
    set_limits(rand_limit(), rand_limit(), rand_limit());
    target = chars_sent + n_chars;
    while (chars_sent < target) begin
      send_random_token(5);
      if (!reprogrammed && chars_sent >= target - n_chars / 2) begin
        set_limits(rand_limit(), rand_limit(), rand_limit());
        reprogrammed = 1'b1;
      end
    end
  endtask

  initial begin
    limits.min_float_len  = MinFloatLenRst;
    limits.max_number_len = MaxNumberLenRst;
    limits.max_ident_len  = MaxIdentLenRst;
    scan_st   = ST_START;
    tok_len   = '0;
    gap_pct   = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_limits();
    test_limit_extremes();
    test_random_tokens(0, 0, 80);
    test_random_tokens(71, 0, 80);
    test_random_tokens(0, 71, 80);
    test_random_tokens(37, 37, 80);

    drain();
    repeat (8) @(posedge clk_i);
    $display("Streamed %0d characters in %0d tokens and checked %0d token classes,",
             chars_sent, tokens_sent, results_checked);
    $display("with %0d limit writes over reset, extreme and random limit settings.",
             cfg_writes);
    if (fail_count == 0) begin
      $display("PASS token_class_recognizer");
    end else begin
      $display("FAIL token_class_recognizer");
    end
    $finish;
  end

  initial begin
    #RunLimit;
    $display("FAIL token_class_recognizer");
    $finish;
  end

endmodule
